### hdl/assert_macros.svh
// Assertion macros for the RTL of the frame receiver.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/dfr_pkg.sv
// Package of the delimited frame receiver: codes, widths and shared types.
// No dependencies.
package dfr_pkg;

   localparam int FRAME_SIZE_DEF = 8;
   localparam int BYTE_W         = 8;
   localparam int TICK_W         = 24;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [TICK_W-1:0] TICK_MAX      = {TICK_W{1'b1}};
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd1000;

   // input op codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // result status codes
   localparam logic [1:0] ST_ACCEPT  = 2'd0;
   localparam logic [1:0] ST_REJECT  = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   // register indexes (address bit 2)
   localparam logic REG_DELIM   = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   // one queued job for the output side
   typedef struct packed {
      logic [1:0] kind;   // status code of the job
      logic       bank;   // frame bank, for accepted frames
   } desc_type;

   // bank handed back by the output side
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   // front status seen by the top level checks
   typedef struct packed {
      logic [1:0] busy;
      logic       wbank;
   } front_stat_type;

endpackage

### hdl/dfr_if.sv
// Word channels of the frame receiver: input items and result items.
// Depends on dfr_pkg.
interface dfr_req_if;
   import dfr_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, op, rx_byte, input ready);
   modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface dfr_rsp_if;
   import dfr_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [BYTE_W-1:0] frame_byte;
   logic              last;
   modport source (output valid, status, frame_byte, last, input ready);
   modport sink   (input valid, status, frame_byte, last, output ready);
endinterface

### hdl/dfr_queue.sv
// Job queue between front and back of the frame receiver.
// Depends on dfr_pkg.
module dfr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dfr_pkg::desc_type push_desc,
   output logic              full,
   input  logic              pop,
   output dfr_pkg::desc_type pop_desc,
   output logic              empty
);
   import dfr_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   desc_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wptr_ff, wptr_in;
   logic [PW-1:0]   rptr_ff, rptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_desc = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = PW'(wptr_ff + 1'b1);
      end
      if (pop) begin
         rptr_in = PW'(rptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_desc;
      end
   end

endmodule

### hdl/dfr_front.sv
// Front of the frame receiver: delimiter hunt, CRC-8, frame checks, timeout.
// Depends on dfr_pkg and dfr_req_if.
module dfr_front #(
   parameter int FRAME_SIZE = dfr_pkg::FRAME_SIZE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   dfr_req_if.sink                               req,
   input  logic [dfr_pkg::BYTE_W-1:0]            delim,
   input  logic [dfr_pkg::TICK_W-1:0]            timeout,
   input  logic                                  q_full,
   output logic                                  q_push,
   output dfr_pkg::desc_type                     q_desc,
   output logic                                  mem_we,
   output logic [$clog2(FRAME_SIZE):0]           mem_addr,
   output logic [dfr_pkg::BYTE_W-1:0]            mem_data,
   input  dfr_pkg::release_type                  rel,
   output dfr_pkg::front_stat_type               stat
);
   import dfr_pkg::*;

   localparam int AW = $clog2(FRAME_SIZE);
   localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_SIZE - 1);

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
      end
      return c;
   endfunction

   logic [AW-1:0]     count_ff, count_in;
   logic [7:0]        crc_ff, crc_in;
   logic [TICK_W-1:0] idle_ff, idle_in;
   logic              size_ok_ff, size_ok_in;
   logic              wbank_ff, wbank_in;
   logic [1:0]        busy_ff, busy_in;

   logic              fire;
   logic [TICK_W-1:0] idle_inc;
   logic [7:0]        crc_next;
   logic              frame_ok;

   assign req.ready = !q_full && !busy_ff[wbank_ff];
   assign fire      = req.valid && req.ready;
   assign idle_inc  = (idle_ff == TICK_MAX) ? idle_ff : TICK_W'(idle_ff + 1'b1);
   assign crc_next  = crc8_update((count_ff == '0) ? 8'hFF : crc_ff, req.rx_byte);
   assign frame_ok  = size_ok_ff && (req.rx_byte == crc_ff);

   assign mem_addr = {wbank_ff, count_ff};
   assign mem_data = req.rx_byte;
   assign mem_we   = fire && (req.op == OP_BYTE) &&
                     ((count_ff != '0) || (req.rx_byte == delim));
   assign stat     = '{busy: busy_ff, wbank: wbank_ff};

   always_comb begin
      count_in   = count_ff;
      crc_in     = crc_ff;
      idle_in    = idle_ff;
      size_ok_in = size_ok_ff;
      wbank_in   = wbank_ff;
      busy_in    = busy_ff;
      q_push     = 1'b0;
      q_desc     = '{kind: ST_ACCEPT, bank: wbank_ff};
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (fire) begin
         if (req.op == OP_TICK) begin
            if (count_ff != '0) begin
               idle_in = idle_inc;
               if (idle_inc > timeout) begin
                  q_push      = 1'b1;
                  q_desc.kind = ST_TIMEOUT;
                  count_in    = '0;
                  crc_in      = 8'hFF;
                  idle_in     = '0;
               end
            end
         end else begin
            idle_in = '0;
            if (count_ff == '0) begin
               if (req.rx_byte == delim) begin
                  crc_in   = crc_next;
                  count_in = AW'(1);
               end
            end else if (count_ff != LAST_IDX) begin
               crc_in   = crc_next;
               count_in = AW'(count_ff + 1'b1);
               if (count_ff == AW'(1)) begin
                  size_ok_in = (req.rx_byte == BYTE_W'(FRAME_SIZE));
               end
            end else begin
               // last byte carries the CRC
               q_push   = 1'b1;
               count_in = '0;
               crc_in   = 8'hFF;
               if (frame_ok) begin
                  q_desc.kind       = ST_ACCEPT;
                  busy_in[wbank_ff] = 1'b1;
                  wbank_in          = !wbank_ff;
               end else begin
                  q_desc.kind = ST_REJECT;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         crc_ff     <= 8'hFF;
         idle_ff    <= '0;
         size_ok_ff <= 1'b0;
         wbank_ff   <= 1'b0;
         busy_ff    <= '0;
      end else begin
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         idle_ff    <= idle_in;
         size_ok_ff <= size_ok_in;
         wbank_ff   <= wbank_in;
         busy_ff    <= busy_in;
      end
   end

endmodule

### hdl/dfr_back.sv
// Back of the frame receiver: two-bank frame memory and result sequencer.
// Depends on dfr_pkg and dfr_rsp_if.
module dfr_back #(
   parameter int FRAME_SIZE = dfr_pkg::FRAME_SIZE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   input  dfr_pkg::desc_type                     q_desc,
   output logic                                  q_pop,
   input  logic                                  mem_we,
   input  logic [$clog2(FRAME_SIZE):0]           mem_addr,
   input  logic [dfr_pkg::BYTE_W-1:0]            mem_data,
   output dfr_pkg::release_type                  rel,
   dfr_rsp_if.source                             rsp
);
   import dfr_pkg::*;

   localparam int AW    = $clog2(FRAME_SIZE);
   localparam int DEPTH = 2 ** (AW + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_SIZE - 1);

   logic [BYTE_W-1:0] mem [DEPTH];

   logic              active_ff, active_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   desc_type          cur_ff;
   logic [1:0]        status_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              last_ff;

   logic              can_load;
   logic              issue;
   logic              is_accept;
   logic              last_byte;

   assign can_load  = !out_valid_ff || rsp.ready;
   assign q_pop     = !active_ff && !q_empty;
   assign issue     = active_ff && can_load;
   assign is_accept = (cur_ff.kind == ST_ACCEPT);
   assign last_byte = (idx_ff == LAST_IDX);
   assign rel       = '{valid: issue && is_accept && last_byte, bank: cur_ff.bank};

   assign rsp.valid      = out_valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.frame_byte = byte_ff;
   assign rsp.last       = last_ff;

   always_comb begin
      active_in    = active_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         active_in = 1'b1;
         idx_in    = '0;
      end
      if (issue) begin
         out_valid_in = 1'b1;
         if (is_accept) begin
            idx_in = AW'(idx_ff + 1'b1);
         end
         if (!is_accept || last_byte) begin
            active_in = 1'b0;
         end
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_data;
      end
   end

   // registered read doubles as the output word register
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_desc;
      end
      if (issue) begin
         status_ff <= cur_ff.kind;
         if (is_accept) begin
            byte_ff <= mem[{cur_ff.bank, idx_ff}];
            last_ff <= last_byte;
         end else begin
            byte_ff <= '0;
            last_ff <= 1'b1;
         end
      end
   end

endmodule

### hdl/delimited_frame_receiver_crc8.sv
// Delimited frame receiver with CRC-8. Input words are received bytes (op 0)
// or time ticks (op 1). Bytes are dropped until one equals delimiter_value;
// from there FRAME_SIZE bytes form a frame, accepted when byte 1 equals
// FRAME_SIZE and the last byte equals CRC-8 (poly 0x07, init 0xFF, MSB first)
// over the bytes before it. An accepted frame comes out as FRAME_SIZE words
// (status 0, last on the final byte); a bad frame gives one status 1 word and
// a partial frame idle for more than timeout_ticks ticks gives one status 2
// word. Throughput: unless stalled, the front takes one input word per cycle;
// within a frame the back emits one result word per cycle unless rsp stalls,
// from a registered read of the two-bank frame memory, and it emits nothing
// between jobs while it loads the next one from the queue. An accepted frame
// holds its bank until its final word is emitted; the input stalls only when
// both banks wait to be emitted or the four-entry job queue is full. Each job
// goes via the queue and the back's job register to the output register.
// Registers: delimiter_value at 0x0, timeout_ticks at 0x4 (decoded by paddr
// bit 2), both readable; write only while idle.
//
// File: top level of the frame receiver, with the register port and checks.
// Depends on dfr_pkg, dfr_if, dfr_queue, dfr_front, dfr_back, assert_macros.svh.
`include "assert_macros.svh"

module delimited_frame_receiver_crc8 #(
   parameter int FRAME_SIZE = dfr_pkg::FRAME_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   dfr_req_if.sink                     req_chan,
   dfr_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import dfr_pkg::*;

   localparam int AW = $clog2(FRAME_SIZE);

   // configuration registers
   logic [BYTE_W-1:0] delim_ff, delim_in;
   logic [TICK_W-1:0] timeout_ff, timeout_in;
   logic              csr_wr;

   // front to queue
   logic              q_push;
   logic              q_full;
   desc_type          push_desc;
   // queue to back
   logic              q_pop;
   logic              q_empty;
   desc_type          pop_desc;
   // frame memory write, front to back
   logic              mem_we;
   logic [AW:0]       mem_addr;
   logic [BYTE_W-1:0] mem_data;
   release_type       rel;
   front_stat_type    fstat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      delim_in   = delim_ff;
      timeout_in = timeout_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_DELIM:   delim_in   = csr_pwdata[BYTE_W-1:0];
            REG_TIMEOUT: timeout_in = csr_pwdata[TICK_W-1:0];
            default:     delim_in   = delim_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_TIMEOUT: csr_prdata = {{(32-TICK_W){1'b0}}, timeout_ff};
         default:     csr_prdata = {{(32-BYTE_W){1'b0}}, delim_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff   <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         delim_ff   <= delim_in;
         timeout_ff <= timeout_in;
      end
   end

   // hunt, CRC and checks; one input word per cycle unless the queue is full or the bank is busy
   dfr_front #(.FRAME_SIZE(FRAME_SIZE)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .delim    (delim_ff),
      .timeout  (timeout_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_desc   (push_desc),
      .mem_we   (mem_we),
      .mem_addr (mem_addr),
      .mem_data (mem_data),
      .rel      (rel),
      .stat     (fstat)
   );

   // jobs: accepted frame (with bank), reject, timeout
   dfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_desc  (pop_desc),
      .empty     (q_empty)
   );

   // frame memory and result words
   dfr_back #(.FRAME_SIZE(FRAME_SIZE)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_desc   (pop_desc),
      .q_pop    (q_pop),
      .mem_we   (mem_we),
      .mem_addr (mem_addr),
      .mem_data (mem_data),
      .rel      (rel),
      .rsp      (rsp_chan)
   );

   // checks
   `ASSERT_IMPLY(a_no_overflow, clock, reset, q_push, !q_full, "job queue overflow")
   `ASSERT_IMPLY(a_no_underflow, clock, reset, q_pop, !q_empty, "job queue underflow")
   `ASSERT_IMPLY(a_bank_free, clock, reset, mem_we, !fstat.busy[mem_addr[AW]],
      "write into a bank still being emitted")
   `ASSERT_IMPLY(a_release_busy, clock, reset, rel.valid, fstat.busy[rel.bank],
      "release of a bank that was not held")
   `ASSERT_IMPLY(a_single_last, clock, reset,
      rsp_chan.valid && (rsp_chan.status != ST_ACCEPT), rsp_chan.last,
      "reject or timeout word without last")

endmodule
